### sv/gdd_pkg.sv
package gdd_pkg;

    // field widths
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MON_W   = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned ST_W    = 2;
    localparam int unsigned AGE_W   = 22;
    localparam int unsigned WD_W    = 3;
    localparam int unsigned DN_W    = 24;   // day number, covers year 16383
    localparam int unsigned OFF_W   = 10;   // day of year offset
    localparam int unsigned Q100_W  = 8;    // year / 100 for a 14 bit year

    localparam int unsigned S_DATA_W  = 24;
    localparam int unsigned M_DATA_W  = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 14;

    localparam int unsigned MAX_YEAR_DEF = 9999;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TODAY_DAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TODAY_MONTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TODAY_YEAR  = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD   = 2'd1;
    localparam logic [ST_W-1:0] ST_SAME  = 2'd2;
    localparam logic [ST_W-1:0] ST_AFTER = 2'd3;

    // x / 100 = (x * 5243) >> 19, exact for x < 43699
    localparam int unsigned DIV100_MUL = 5243;
    localparam int unsigned DIV100_SH  = 19;
    localparam int unsigned DIV100_PW  = 27;
    // x / 7 from below: (x * 599186) >> 22, off by at most one under 2^22,
    // which holds every legal day number
    localparam int unsigned DIV7_MUL = 599186;
    localparam int unsigned DIV7_SH  = 22;
    localparam int unsigned DIV7_PW  = 44;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    function automatic logic [8:0] days_before(input logic [MON_W-1:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:    r = leap ? 5'd29 : 5'd28;
            4'd4:    r = 5'd30;
            4'd6:    r = 5'd30;
            4'd9:    r = 5'd30;
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

### sv/gregorian_date_difference.sv
// Date checker against a reference date. Each transaction on the slave
// stream carries one Gregorian date; the block answers with one
// transaction on the master stream holding a status (ok, malformed, equal
// to the reference, after the reference), the number of days from the
// date up to the reference date (saturated to 22 bits, zero unless the
// status is ok), the weekday (0 = Monday, zero for a malformed date) and
// an anniversary flag. The reference date is written through the cfg port;
// the user must write it only while no transaction is in flight; the block
// itself does not enforce this. Throughput is one date per clock when
// m_tready does not stall the output. There are five register stages (four
// compute stages plus the output register), the first of them loaded at the
// accepting edge. Stall back-pressure walks back stage by stage, so bubbles
// are squeezed out and s_tready stays high while any stage is empty.
module gregorian_date_difference
    import gdd_pkg::*;
#(
    parameter int unsigned MAX_YEAR = gdd_pkg::MAX_YEAR_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [gdd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gdd_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [4:0] birth_day, [8:5] birth_month, [22:9] birth_year, [23] zero
    input  logic [gdd_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] status, [23:2] age_days, [26:24] weekday, [27] anniversary,
    // [31:28] zero
    output logic [gdd_pkg::M_DATA_W-1:0]   m_tdata
);

    // ---------------------------------------------------------------
    // reference date registers
    // ---------------------------------------------------------------
    logic [DAY_W-1:0]  today_day_reg;
    logic [MON_W-1:0]  today_month_reg;
    logic [YEAR_W-1:0] today_year_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            today_day_reg   <= DAY_W'(1);
            today_month_reg <= MON_W'(1);
            today_year_reg  <= YEAR_W'(1);
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_TODAY_DAY:   today_day_reg   <= cfg_wdata[DAY_W-1:0];
                REG_TODAY_MONTH: today_month_reg <= cfg_wdata[MON_W-1:0];
                REG_TODAY_YEAR:  today_year_reg  <= cfg_wdata[YEAR_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // handshake: each stage moves when empty or when the next one moves
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy_out;

    assign rdy_out  = !out_valid_reg || m_tready;
    assign rdy4     = !v4_reg || rdy_out;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)    v1_reg        <= s_tvalid;
            if (rdy2)    v2_reg        <= v1_reg;
            if (rdy3)    v3_reg        <= v2_reg;
            if (rdy4)    v4_reg        <= v3_reg;
            if (rdy_out) out_valid_reg <= v4_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: order compare, anniversary match, reference saturation, divide years by 100
    // lane 0 is the queried date, lane 1 the reference date
    // ---------------------------------------------------------------
    logic [DAY_W-1:0]  bd;
    logic [MON_W-1:0]  bm;
    logic [YEAR_W-1:0] by;
    logic [MON_W-1:0]  rm;
    logic [YEAR_W-1:0] ry;

    assign bd   = s_tdata[DAY_W-1:0];
    assign bm   = s_tdata[DAY_W +: MON_W];
    assign by   = s_tdata[DAY_W+MON_W +: YEAR_W];

    always_comb
    begin
        if (today_month_reg == '0)
            rm = MON_W'(1);
        else if (today_month_reg > MON_W'(12))
            rm = MON_W'(12);
        else
            rm = today_month_reg;
        ry = (today_year_reg == '0) ? YEAR_W'(1) : today_year_reg;
    end

    logic [DAY_W-1:0]  d1_next   [2];
    logic [MON_W-1:0]  m1_next   [2];
    logic [YEAR_W-1:0] y1_next   [2];
    logic [YEAR_W-1:0] p1_next   [2];
    logic [Q100_W-1:0] qy1_next  [2];
    logic [Q100_W-1:0] qp1_next  [2];
    logic [DIV100_PW-1:0] prod_y [2];
    logic [DIV100_PW-1:0] prod_p [2];
    logic same1_next, after1_next, anniv1_next, neg1_next;

    logic [DAY_W-1:0]  d1_reg   [2];
    logic [MON_W-1:0]  m1_reg   [2];
    logic [YEAR_W-1:0] y1_reg   [2];
    logic [YEAR_W-1:0] p1_reg   [2];
    logic [Q100_W-1:0] qy1_reg  [2];
    logic [Q100_W-1:0] qp1_reg  [2];
    logic same1_reg, after1_reg, anniv1_reg, neg1_reg;

    always_comb
    begin
        d1_next[0] = bd;
        m1_next[0] = bm;
        y1_next[0] = by;
        d1_next[1] = today_day_reg;
        m1_next[1] = rm;
        y1_next[1] = ry;
        for (int l = 0; l < 2; l++)
        begin
            p1_next[l]  = y1_next[l] - YEAR_W'(1);
            prod_y[l]   = DIV100_PW'(y1_next[l]) * DIV100_PW'(DIV100_MUL);
            prod_p[l]   = DIV100_PW'(p1_next[l]) * DIV100_PW'(DIV100_MUL);
            qy1_next[l] = prod_y[l][DIV100_SH +: Q100_W];
            qp1_next[l] = prod_p[l][DIV100_SH +: Q100_W];
        end

        // order on raw fields: year, then month, then day
        same1_next = (by == today_year_reg) && (bm == today_month_reg)
                     && (bd == today_day_reg);
        if (by != today_year_reg)
            after1_next = by > today_year_reg;
        else if (bm != today_month_reg)
            after1_next = bm > today_month_reg;
        else
            after1_next = bd > today_day_reg;

        anniv1_next = (bd == today_day_reg) && (bm == today_month_reg);
        // reference day 0 of January in year 1 lies before day zero
        neg1_next   = (ry == YEAR_W'(1)) && (rm == MON_W'(1))
                      && (today_day_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            for (int l = 0; l < 2; l++)
            begin
                d1_reg[l]  <= d1_next[l];
                m1_reg[l]  <= m1_next[l];
                y1_reg[l]  <= y1_next[l];
                p1_reg[l]  <= p1_next[l];
                qy1_reg[l] <= qy1_next[l];
                qp1_reg[l] <= qp1_next[l];
            end
            same1_reg  <= same1_next;
            after1_reg <= after1_next;
            anniv1_reg <= anniv1_next;
            neg1_reg   <= neg1_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: leap years, validity, status, day of year offset, year part of the day number
    // ---------------------------------------------------------------
    logic              leap2      [2];
    logic [DN_W-1:0]   n1_2_next  [2];
    logic [OFF_W-1:0]  off2_next  [2];
    logic [ST_W-1:0]   st2_next;
    logic              valid2;

    logic [DN_W-1:0]   n1_2_reg   [2];
    logic [OFF_W-1:0]  off2_reg   [2];
    logic [ST_W-1:0]   st2_reg;
    logic              anniv2_reg, neg2_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            leap2[l] = (y1_reg[l][1:0] == 2'b00)
                       && ((YEAR_W'(qy1_reg[l]) * YEAR_W'(100) != y1_reg[l])
                           || (qy1_reg[l][1:0] == 2'b00));
            n1_2_next[l] = DN_W'(p1_reg[l]) * DN_W'(365)
                           + DN_W'(p1_reg[l] >> 2)
                           - DN_W'(qp1_reg[l])
                           + DN_W'(qp1_reg[l] >> 2);
            off2_next[l] = OFF_W'(days_before(m1_reg[l]))
                           + OFF_W'((m1_reg[l] > MON_W'(2)) && leap2[l])
                           + OFF_W'(d1_reg[l]);
        end

        valid2 = (y1_reg[0] != '0) && (32'(y1_reg[0]) <= 32'(MAX_YEAR))
                 && (m1_reg[0] >= MON_W'(1)) && (m1_reg[0] <= MON_W'(12))
                 && (d1_reg[0] != '0)
                 && (d1_reg[0] <= month_len(m1_reg[0], leap2[0]));

        if (!valid2)
            st2_next = ST_BAD;
        else if (same1_reg)
            st2_next = ST_SAME;
        else if (after1_reg)
            st2_next = ST_AFTER;
        else
            st2_next = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            for (int l = 0; l < 2; l++)
            begin
                n1_2_reg[l] <= n1_2_next[l];
                off2_reg[l] <= off2_next[l];
            end
            st2_reg    <= st2_next;
            anniv2_reg <= anniv1_reg;
            neg2_reg   <= neg1_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: full day numbers
    // ---------------------------------------------------------------
    logic [DN_W-1:0] bn3_reg, rn3_reg;
    logic [ST_W-1:0] st3_reg;
    logic            anniv3_reg, neg3_reg;
    logic [DN_W-1:0] bn3_next, rn3_next;

    assign bn3_next = n1_2_reg[0] + DN_W'(off2_reg[0]) - DN_W'(1);
    assign rn3_next = n1_2_reg[1] + DN_W'(off2_reg[1]) - DN_W'(1);

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            bn3_reg    <= bn3_next;
            rn3_reg    <= rn3_next;
            st3_reg    <= st2_reg;
            anniv3_reg <= anniv2_reg;
            neg3_reg   <= neg2_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: difference with saturation, quotient estimate for mod 7
    // ---------------------------------------------------------------
    logic [DN_W-1:0]    diff4;
    logic [DIV7_PW-1:0] prod7;
    logic [AGE_W-1:0]   age4_next;
    logic [3:0]         q4_next;

    logic [AGE_W-1:0]   age4_reg;
    logic [3:0]         q4_reg, bnl4_reg;
    logic [ST_W-1:0]    st4_reg;
    logic               anniv4_reg;

    always_comb
    begin
        diff4 = rn3_reg - bn3_reg;
        if ((st3_reg != ST_OK) || neg3_reg || (rn3_reg <= bn3_reg))
            age4_next = '0;
        else if (diff4 > DN_W'(AGE_MAX))
            age4_next = AGE_MAX;
        else
            age4_next = diff4[AGE_W-1:0];
        prod7   = DIV7_PW'(bn3_reg) * DIV7_PW'(DIV7_MUL);
        // only the low nibble is needed: remainder is below 16
        q4_next = prod7[DIV7_SH +: 4];
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            age4_reg   <= age4_next;
            q4_reg     <= q4_next;
            bnl4_reg   <= bn3_reg[3:0];
            st4_reg    <= st3_reg;
            anniv4_reg <= anniv3_reg;
        end
    end

    // ---------------------------------------------------------------
    // output register: remainder correction and packing
    // ---------------------------------------------------------------
    logic [3:0]       rem_raw;
    logic [WD_W-1:0]  wd_next;
    logic [WD_W-1:0]  wd_reg;
    logic [AGE_W-1:0] age_reg;
    logic [ST_W-1:0]  st_reg;
    logic             anniv_reg;

    always_comb
    begin
        rem_raw = bnl4_reg - q4_reg * 4'd7;
        if (st4_reg == ST_BAD)
            wd_next = '0;
        else if (rem_raw >= 4'd7)
            wd_next = WD_W'(rem_raw - 4'd7);
        else
            wd_next = rem_raw[WD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy_out)
        begin
            st_reg    <= st4_reg;
            age_reg   <= age4_reg;
            wd_reg    <= wd_next;
            anniv_reg <= anniv4_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, anniv_reg, wd_reg, age_reg, st_reg};

`ifndef SYNTH
    // a malformed date reports neither age nor weekday
    a_bad_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && st_reg == ST_BAD) |-> (age_reg == '0 && wd_reg == '0))
        else $error("malformed date with non-zero age or weekday");

    // a day count only comes with an ok status
    a_age_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && age_reg != '0) |-> (st_reg == ST_OK))
        else $error("age reported with status other than ok");

    // mod 7 correction leaves a weekday code
    a_wd_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (wd_reg < WD_W'(7)))
        else $error("weekday out of range");

    // a stalled result is not overwritten
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(m_tdata)))
        else $error("stalled result changed");
`endif

endmodule
